FILE: rtl/core/swmf_pkg.sv
// ----------------------------------------------------------------------------
// swmf_pkg
// Shared types and constants of the sliding window maximum filter.
// ----------------------------------------------------------------------------
package swmf_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int WINDOW_MAX  = 64;
  localparam int IDX_W       = $clog2(WINDOW_MAX);
  localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
  localparam int POS_W       = 8;
  localparam int WS_W        = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int REG_IDX_W   = CFG_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;
  localparam logic [WS_W-1:0]      WS_RESET        = 7'd1;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] sample;
    logic                         first;
    logic                         last;
  } item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] window_max;
    logic                         last_window;
  } result_t;

  typedef struct packed {
    logic [POS_W-1:0]             pos;
    logic signed [DATA_WIDTH-1:0] value;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXPIRE,
    S_POP,
    S_PUSH,
    S_EMIT
  } eng_state_t;

  typedef struct packed {
    eng_state_t       state;
    logic [CNT_W-1:0] count;
  } eng_status_t;

endpackage

FILE: rtl/core/swmf_queue.sv
// ----------------------------------------------------------------------------
// swmf_queue
// Front end: accepts input words into a short queue ahead of the deque engine.
// ----------------------------------------------------------------------------
module swmf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  swmf_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_pop,
  output swmf_pkg::item_t q_item
);
  import swmf_pkg::*;

  item_t             store [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] fill_r, fill_nxt;
  logic              push, pop;

  assign in_ready = (fill_r != QCNT_W'(QUEUE_DEPTH));
  assign q_valid  = (fill_r != '0);
  assign q_item   = store[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr_r] <= in_item;
    end
  end

endmodule

FILE: rtl/core/swmf_engine.sv
// ----------------------------------------------------------------------------
// swmf_engine
// Back end: monotonic deque in a single-port-read memory, one pop per cycle.
// ----------------------------------------------------------------------------
module swmf_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [swmf_pkg::WS_W-1:0]     window_size,
  input  logic                          q_valid,
  input  swmf_pkg::item_t               q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output swmf_pkg::result_t             out_result,
  output swmf_pkg::eng_status_t         status
);
  import swmf_pkg::*;

  eng_state_t                   state_r, state_nxt;
  logic [IDX_W-1:0]             fp_r, fp_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [POS_W-1:0]             pos_r, pos_nxt;
  logic [CNT_W-1:0]             seen_r, seen_nxt;
  logic signed [DATA_WIDTH-1:0] val_r, val_nxt;
  logic                         last_r, last_nxt;
  logic                         direct_r, direct_nxt;
  logic                         out_valid_r, out_valid_nxt;
  result_t                      out_res_r, out_res_nxt;

  entry_t           mem [WINDOW_MAX];
  entry_t           rd_q_r;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             mem_we;

  logic [CNT_W-1:0] k_eff;
  logic [POS_W-1:0] age;
  logic             expire, pop_hit, full, emit, out_free;
  logic [IDX_W-1:0] fp_exp, fp_push;
  logic [CNT_W-1:0] cnt_exp, cnt_push, seen_inc;

  always_comb begin
    if (window_size == '0) begin
      k_eff = CNT_W'(1);
    end else if (CNT_W'(window_size) > CNT_W'(WINDOW_MAX)) begin
      k_eff = CNT_W'(WINDOW_MAX);
    end else begin
      k_eff = CNT_W'(window_size);
    end
  end

  assign age      = pos_r - rd_q_r.pos;
  assign expire   = (cnt_r != '0) && (age >= POS_W'(k_eff));
  assign fp_exp   = fp_r + IDX_W'(expire);
  assign cnt_exp  = cnt_r - CNT_W'(expire);
  assign pop_hit  = (cnt_r != '0) && (rd_q_r.value <= val_r);
  assign full     = (cnt_r == CNT_W'(WINDOW_MAX));
  assign fp_push  = fp_r + IDX_W'(full);
  assign cnt_push = cnt_r - CNT_W'(full);
  assign seen_inc = (seen_r < CNT_W'(WINDOW_MAX)) ? seen_r + CNT_W'(1) : seen_r;
  assign emit     = (seen_inc >= k_eff);
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          state_nxt = S_EXPIRE;
        end
      end
      S_EXPIRE: begin
        state_nxt = S_POP;
      end
      S_POP: begin
        if (!pop_hit) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        state_nxt = emit ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    fp_nxt        = fp_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    seen_nxt      = seen_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    direct_nxt    = direct_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    rd_addr       = fp_r;
    wr_addr       = fp_push + cnt_push[IDX_W-1:0];
    mem_we        = 1'b0;
    q_pop         = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          val_nxt  = q_item.sample;
          last_nxt = q_item.last;
          if (q_item.first) begin
            fp_nxt   = '0;
            cnt_nxt  = '0;
            pos_nxt  = '0;
            seen_nxt = '0;
          end
        end
      end
      S_EXPIRE: begin
        fp_nxt  = fp_exp;
        cnt_nxt = cnt_exp;
        rd_addr = fp_exp + cnt_exp[IDX_W-1:0] - IDX_W'(1);
      end
      S_POP: begin
        if (pop_hit) begin
          cnt_nxt = cnt_r - CNT_W'(1);
          rd_addr = fp_r + cnt_r[IDX_W-1:0] - IDX_W'(2);
        end
      end
      S_PUSH: begin
        mem_we     = 1'b1;
        fp_nxt     = fp_push;
        cnt_nxt    = cnt_push + CNT_W'(1);
        pos_nxt    = pos_r + POS_W'(1);
        seen_nxt   = seen_inc;
        // empty deque: the new sample is the front, memory read would be stale
        direct_nxt = (cnt_push == '0);
        rd_addr    = fp_push;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_res_nxt.window_max  = direct_r ? val_r : rd_q_r.value;
          out_res_nxt.last_window = last_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fp_r        <= '0;
      cnt_r       <= '0;
      pos_r       <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fp_r        <= fp_nxt;
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r     <= val_nxt;
    last_r    <= last_nxt;
    direct_r  <= direct_nxt;
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= '{pos: pos_r, value: val_r};
    end
    rd_q_r <= mem[rd_addr];
  end

  assign out_valid    = out_valid_r;
  assign out_result   = out_res_r;
  assign status.state = state_r;
  assign status.count = cnt_r;

endmodule

FILE: rtl/core/sliding_window_max_filter_core.sv
// ----------------------------------------------------------------------------
// sliding_window_max_filter_core
// Streaming running maximum over a configurable window of signed samples.
// ----------------------------------------------------------------------------
// Input words arrive on in_t* (tdata = sample, tuser = first, tlast = last);
// first opens a new array. Results leave on out_t* (tdata = window maximum,
// tlast = result of the array's final sample). A sample gives a result only
// once window_size samples of its array have been seen.
// window_size is written over the APB port at address 0 while the stream is
// idle; 0 acts as 1 and values above 64 act as 64.
// Input words go into a 4-word queue; the deque engine takes one word at a
// time and steps it through take, expire, pop and push, and then emit when
// it gives a result; in the pop step it pops deque entries one per cycle
// (single memory read port). Each sample is popped at most once.
// Reset clears the deque, the counters, the queue and sets window_size to 1.
// A stalled output holds its word; the engine waits and the queue fills,
// then in_tready drops.
// ----------------------------------------------------------------------------
module sliding_window_max_filter_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [swmf_pkg::DATA_WIDTH-1:0]     in_tdata,   // [31:0] sample
  input  logic                                in_tuser,   // [0] first
  input  logic                                in_tlast,   // last
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [swmf_pkg::DATA_WIDTH-1:0]     out_tdata,  // [31:0] window_max
  output logic                                out_tlast,  // last_window
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [swmf_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [swmf_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [swmf_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import swmf_pkg::*;

  logic [WS_W-1:0]      window_size_r, window_size_nxt;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  item_t       in_item, q_item;
  logic        q_valid, q_pop;
  result_t     out_result;
  eng_status_t eng_status;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (reg_idx == REG_WINDOW_SIZE) ? CFG_DATA_W'(window_size_r) : '0;

  always_comb begin
    window_size_nxt = window_size_r;
    if (cfg_wr && (reg_idx == REG_WINDOW_SIZE)) begin
      window_size_nxt = cfg_pwdata[WS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WS_RESET;
    end else begin
      window_size_r <= window_size_nxt;
    end
  end

  assign in_item.sample = in_tdata;
  assign in_item.first  = in_tuser;
  assign in_item.last   = in_tlast;

  swmf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  swmf_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .window_size (window_size_r),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_result  (out_result),
    .status      (eng_status)
  );

  assign out_tdata = out_result.window_max;
  assign out_tlast = out_result.last_window;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    eng_status.count <= CNT_W'(WINDOW_MAX))
    else $error("deque count above depth");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(eng_status.state == S_EMIT))
    else $error("result word raised outside emit step");

  a_ws_reset: assert property (@(posedge clk)
    !rst_n |=> (window_size_r == WS_RESET))
    else $error("window_size not restored by reset");

endmodule
